// ----- src/utmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utmr_pkg
// Shared codes, characters and types of the tracker message recognizer.
// ----------------------------------------------------------------------------
package utmr_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int IN_W     = BYTE_W + LEN_W;
  localparam int OUT_W    = 8;

  // Verdict codes
  localparam logic [1:0] V_PENDING = 2'd0;
  localparam logic [1:0] V_MATCH   = 2'd1;
  localparam logic [1:0] V_INVALID = 2'd2;

  // Message kinds
  localparam logic [1:0] K_UNKNOWN  = 2'd0;
  localparam logic [1:0] K_QUERY    = 2'd1;
  localparam logic [1:0] K_RESPONSE = 2'd2;
  localparam logic [1:0] K_ERROR    = 2'd3;

  // Shortest legal payload and length of the closing text "1:y1:" + kind + 'e'
  localparam int MIN_PAYLOAD = 13;
  localparam int TAIL_SPAN   = 7;

  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
  localparam logic [7:0] CH_Y     = 8'h79;  // 'y'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_Q     = 8'h71;  // 'q'

  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] message_kind;
  } result_t;

  // Opening kind byte: 'a', 'r' or 'e'; unknown otherwise
  function automatic logic [1:0] open_kind(input logic [7:0] b);
    logic [1:0] k;
    k = K_UNKNOWN;
    if (b == CH_A) k = K_QUERY;
    else if (b == CH_R) k = K_RESPONSE;
    else if (b == CH_E) k = K_ERROR;
    return k;
  endfunction

  // Closing kind letter: 'q', 'r' or 'e'; unknown otherwise
  function automatic logic [1:0] close_kind(input logic [7:0] b);
    logic [1:0] k;
    k = K_UNKNOWN;
    if (b == CH_Q) k = K_QUERY;
    else if (b == CH_R) k = K_RESPONSE;
    else if (b == CH_E) k = K_ERROR;
    return k;
  endfunction

endpackage

// ----- src/utmr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utmr_parser
// Per-packet parse state and the single-pass next-state logic for one byte.
// ----------------------------------------------------------------------------
module utmr_parser #(
  parameter int LENGTH_BITS = utmr_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [utmr_pkg::BYTE_W-1:0]   payload_byte,
  input  logic [utmr_pkg::LEN_W-1:0]    payload_length,
  input  logic                          packet_start,
  output utmr_pkg::result_t             result
);
  import utmr_pkg::*;

  localparam logic [2:0] PH_BANNER    = 3'd0;
  localparam logic [2:0] PH_KIND      = 3'd1;
  localparam logic [2:0] PH_SKIP      = 3'd2;
  localparam logic [2:0] PH_TAIL      = 3'd3;
  localparam logic [2:0] PH_TAIL_KIND = 3'd4;
  localparam logic [2:0] PH_LAST      = 3'd5;

  localparam logic [LENGTH_BITS-1:0] OFF_MAX  = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] MIN_LEN  = LENGTH_BITS'(MIN_PAYLOAD);
  localparam logic [LENGTH_BITS-1:0] TAIL_LEN = LENGTH_BITS'(TAIL_SPAN);

  logic [2:0]             parse_phase, parse_phase_next;
  logic [2:0]             match_position, match_position_next;
  logic [LENGTH_BITS-1:0] byte_offset, byte_offset_next;
  logic [1:0]             seen_kind, seen_kind_next;
  logic [1:0]             held_verdict, held_verdict_next;

  logic [2:0]             cur_phase, cur_pos;
  logic [LENGTH_BITS-1:0] cur_off, len, tail_start;
  logic [1:0]             cur_kind, cur_verdict, exam;
  logic [7:0]             head_char, tail_char;

  always_comb begin
    // Packet start restarts the parse before this byte is examined
    cur_phase   = packet_start ? PH_BANNER : parse_phase;
    cur_pos     = packet_start ? 3'd0 : match_position;
    cur_off     = packet_start ? '0 : byte_offset;
    cur_kind    = packet_start ? K_UNKNOWN : seen_kind;
    cur_verdict = packet_start ? V_PENDING : held_verdict;

    len        = payload_length[LENGTH_BITS-1:0];
    tail_start = len - TAIL_LEN;

    case (cur_pos)
      3'd0:    head_char = CH_D;
      3'd1:    head_char = CH_ONE;
      default: head_char = CH_COLON;
    endcase
    case (cur_pos)
      3'd0:    tail_char = CH_ONE;
      3'd1:    tail_char = CH_COLON;
      3'd2:    tail_char = CH_Y;
      3'd3:    tail_char = CH_ONE;
      default: tail_char = CH_COLON;
    endcase

    parse_phase_next    = cur_phase;
    match_position_next = cur_pos;
    seen_kind_next      = cur_kind;
    exam                = V_PENDING;

    if (len < MIN_LEN || cur_off >= len) begin
      exam = V_INVALID;
    end else begin
      unique case (cur_phase)
        PH_BANNER: begin
          if (cur_pos > 3'd2 || payload_byte != head_char) begin
            exam = V_INVALID;
          end else begin
            if (cur_pos == 3'd2) parse_phase_next = PH_KIND;
            match_position_next = cur_pos + 3'd1;
          end
        end
        PH_KIND: begin
          if (open_kind(payload_byte) == K_UNKNOWN) begin
            exam = V_INVALID;
          end else begin
            seen_kind_next   = open_kind(payload_byte);
            parse_phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (cur_off < tail_start) begin
            exam = V_PENDING;
          end else if (cur_off == tail_start && payload_byte == CH_ONE) begin
            parse_phase_next    = PH_TAIL;
            match_position_next = 3'd1;
          end else begin
            exam = V_INVALID;
          end
        end
        PH_TAIL: begin
          if (cur_pos > 3'd4 || payload_byte != tail_char) begin
            exam = V_INVALID;
          end else begin
            if (cur_pos == 3'd4) parse_phase_next = PH_TAIL_KIND;
            match_position_next = cur_pos + 3'd1;
          end
        end
        PH_TAIL_KIND: begin
          if (close_kind(payload_byte) == K_UNKNOWN ||
              close_kind(payload_byte) != cur_kind) begin
            exam = V_INVALID;
          end else begin
            parse_phase_next = PH_LAST;
          end
        end
        PH_LAST: begin
          exam = (payload_byte == CH_E) ? V_MATCH : V_INVALID;
        end
        default: begin
          exam = V_INVALID;
        end
      endcase
    end

    // A settled verdict freezes the parse until the next packet
    if (cur_verdict != V_PENDING) begin
      parse_phase_next    = cur_phase;
      match_position_next = cur_pos;
      seen_kind_next      = cur_kind;
      held_verdict_next   = cur_verdict;
    end else begin
      held_verdict_next   = exam;
    end

    byte_offset_next = (cur_off != OFF_MAX) ? cur_off + 1'b1 : cur_off;

    result.verdict      = held_verdict_next;
    result.message_kind = seen_kind_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_BANNER;
      match_position <= 3'd0;
      byte_offset    <= '0;
      seen_kind      <= K_UNKNOWN;
      held_verdict   <= V_PENDING;
    end else if (accept) begin
      parse_phase    <= parse_phase_next;
      match_position <= match_position_next;
      byte_offset    <= byte_offset_next;
      seen_kind      <= seen_kind_next;
      held_verdict   <= held_verdict_next;
    end
  end

  // Settled verdict holds for the rest of the packet
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && !packet_start && held_verdict != V_PENDING
    |=> held_verdict == $past(held_verdict) && seen_kind == $past(seen_kind))
    else $error("held verdict changed inside a packet");

  // Past the kind byte a kind has always been recorded
  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_SKIP || parse_phase == PH_TAIL ||
     parse_phase == PH_TAIL_KIND || parse_phase == PH_LAST)
    |-> seen_kind != K_UNKNOWN)
    else $error("parse beyond kind byte with no kind recorded");

  // A match is only reachable from the final phase
  a_match_from_last: assert property (@(posedge clk) disable iff (rst)
    accept && !packet_start && held_verdict == V_PENDING &&
    parse_phase != PH_LAST |=> held_verdict != V_MATCH)
    else $error("match outside the final phase");

  // Offset counts up and saturates inside a packet
  a_offset: assert property (@(posedge clk) disable iff (rst)
    accept && !packet_start |=> byte_offset >= $past(byte_offset))
    else $error("byte offset went backwards");

endmodule

// ----- src/utmr_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utmr_out_reg
// Result register on the master side; frees the slave side while it drains.
// ----------------------------------------------------------------------------
module utmr_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  utmr_pkg::result_t            result,
  output logic                         can_load,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [utmr_pkg::OUT_W-1:0]   m_axis_tdata
);
  import utmr_pkg::*;

  result_t held;

  // Take a new result when empty or when the current one leaves this cycle
  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {4'b0000, held.message_kind, held.verdict};

endmodule

// ----- src/udp_tracker_message_recognizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_tracker_message_recognizer_core
// Byte-stream recognizer for bencoded UDP tracker messages.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side carries one payload byte per beat with the packet length;
//   s_axis_tuser marks the first byte of a packet and restarts the parse.
//   Every input beat yields exactly one master-side beat: a verdict
//   (pending, matched, invalid) and the message kind seen so far.
//   Matched or invalid is held for the remaining bytes of the packet.
// Timing and throughput:
//   The result of an accepted byte is registered and shows on the master side
//   in the next cycle. One byte per cycle sustained while m_axis_tready
//   stays high; the parse state update is a single compare-and-select pass
//   between the state registers and the result register.
// Reset:
//   rst (synchronous) empties the result register and returns the parse
//   to the start of a packet at offset zero, so bytes arriving without a
//   packet start mark are parsed as a packet beginning there.
// Stall:
//   When m_axis_tready is low and a result is waiting, s_axis_tready
//   drops; nothing is lost and the waiting result is held steady.
// ----------------------------------------------------------------------------
module udp_tracker_message_recognizer_core #(
  parameter int LENGTH_BITS = utmr_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [utmr_pkg::IN_W-1:0]   s_axis_tdata,  // [7:0] payload_byte, [23:8] payload_length
  input  logic                        s_axis_tuser,  // [0] packet_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [utmr_pkg::OUT_W-1:0]  m_axis_tdata   // [1:0] verdict, [3:2] message_kind, zero fill
);
  import utmr_pkg::*;

  logic    accept;
  logic    can_load;
  result_t result;

  // Accept a beat whenever the result register can take its result
  assign s_axis_tready = can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  utmr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .payload_byte   (s_axis_tdata[BYTE_W-1:0]),
    .payload_length (s_axis_tdata[IN_W-1:BYTE_W]),
    .packet_start   (s_axis_tuser),
    .result         (result)
  );

  utmr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- tb/udp_tracker_message_recognizer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_tracker_message_recognizer_core_test
// Self-checking bench for the tracker message recognizer. It streams payload
// bytes, both well-formed tracker messages and damaged ones. A scoreboard
// predicts one verdict beat per byte and compares each result beat with it.
// Both stream sides idle and stall at random, and one long receiver hold-off
// fills the block up.
// ----------------------------------------------------------------------------
module udp_tracker_message_recognizer_core_test;
  import utmr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;

  // Scan phases of the scoreboard's own parser
  typedef enum logic [2:0] {
    SCAN_BANNER, SCAN_KIND, SCAN_BODY, SCAN_TRAILER, SCAN_TRAILER_KIND, SCAN_CLOSE
  } scan_phase_t;

  // Ways a generated message gets damaged
  typedef enum int {
    FLAW_NONE, FLAW_CORRUPT, FLAW_LENGTH, FLAW_KIND_MISMATCH, FLAW_TRUNCATE,
    FLAW_EXTRA, FLAW_LENGTH_SHIFT
  } flaw_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // [7:0] payload_byte, [23:8] payload_length
  logic              s_axis_tuser = 1'b0; // [0] packet_start
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // [1:0] verdict, [3:2] message_kind

  udp_tracker_message_recognizer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Parser state of the scoreboard
  scan_phase_t scan_phase   = SCAN_BANNER;
  logic [2:0]  scan_pos     = '0;
  logic [15:0] scan_offset  = '0;
  logic [1:0]  seen_kind    = K_UNKNOWN;
  logic [1:0]  held_verdict = V_PENDING;

  result_t verdict_q[$];  // expected verdict beats, oldest first

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int holds_done    = 0;
  int beats_sent    = 0;
  int beats_checked = 0;
  int packets_sent  = 0;
  int matched_seen  = 0;
  int invalid_seen  = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Scoreboard parser
  // ---------------------------------------------------------------------------

  // Judge one byte against the parse; returns the new verdict.
  function automatic logic [1:0] judge_byte(input logic [7:0] b, input logic [15:0] len);
    logic [7:0] want_ch;
    logic [1:0] close_k;
    if (len < MIN_PAYLOAD || scan_offset >= len) return V_INVALID;
    case (scan_phase)
      SCAN_BANNER: begin
        case (scan_pos)
          3'd0:    want_ch = CH_D;
          3'd1:    want_ch = CH_ONE;
          default: want_ch = CH_COLON;
        endcase
        if (scan_pos > 3'd2 || b != want_ch) return V_INVALID;
        if (scan_pos == 3'd2) scan_phase = SCAN_KIND;
        scan_pos = scan_pos + 3'd1;
        return V_PENDING;
      end
      SCAN_KIND: begin
        if (b == CH_A) seen_kind = K_QUERY;
        else if (b == CH_R) seen_kind = K_RESPONSE;
        else if (b == CH_E) seen_kind = K_ERROR;
        else return V_INVALID;
        scan_phase = SCAN_BODY;
        return V_PENDING;
      end
      SCAN_BODY: begin
        // skip the middle; the trailer must start exactly TAIL_SPAN from the end
        if (scan_offset < len - TAIL_SPAN) return V_PENDING;
        if (scan_offset == len - TAIL_SPAN && b == CH_ONE) begin
          scan_phase = SCAN_TRAILER;
          scan_pos   = 3'd1;
          return V_PENDING;
        end
        return V_INVALID;
      end
      SCAN_TRAILER: begin
        case (scan_pos)
          3'd0, 3'd3: want_ch = CH_ONE;
          3'd2:       want_ch = CH_Y;
          default:    want_ch = CH_COLON;
        endcase
        if (scan_pos > 3'd4 || b != want_ch) return V_INVALID;
        if (scan_pos == 3'd4) scan_phase = SCAN_TRAILER_KIND;
        scan_pos = scan_pos + 3'd1;
        return V_PENDING;
      end
      SCAN_TRAILER_KIND: begin
        if (b == CH_Q) close_k = K_QUERY;
        else if (b == CH_R) close_k = K_RESPONSE;
        else if (b == CH_E) close_k = K_ERROR;
        else return V_INVALID;
        if (close_k != seen_kind) return V_INVALID;
        scan_phase = SCAN_CLOSE;
        return V_PENDING;
      end
      SCAN_CLOSE: return (b == CH_E) ? V_MATCH : V_INVALID;
      default:    return V_INVALID;
    endcase
  endfunction

  // Advance the parser by one accepted byte and give its verdict beat.
  task automatic recognize_byte(input logic [7:0] b, input logic [15:0] len,
                                input logic first, output result_t res);
    if (first) begin
      scan_phase   = SCAN_BANNER;
      scan_pos     = '0;
      scan_offset  = '0;
      seen_kind    = K_UNKNOWN;
      held_verdict = V_PENDING;
    end
    // a settled verdict is held without looking at the byte
    if (held_verdict == V_PENDING) held_verdict = judge_byte(b, len);
    if (scan_offset != '1) scan_offset = scan_offset + 16'd1;
    res.verdict      = held_verdict;
    res.message_kind = seen_kind;
  endtask

  function automatic logic [7:0] kind_char(input logic [1:0] kind, input bit closing);
    case (kind)
      K_QUERY:    kind_char = closing ? CH_Q : CH_A;
      K_RESPONSE: kind_char = CH_R;
      default:    kind_char = CH_E;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream drivers
  // ---------------------------------------------------------------------------

  // Offer one byte, wait for the handshake, log its expected verdict beat.
  task automatic send_beat(input logic [7:0] b, input logic [15:0] len, input logic first);
    result_t res;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, b};
    s_axis_tuser  <= first;
    do @(posedge clk); while (!s_axis_tready);
    recognize_byte(b, len, first, res);
    verdict_q.push_back(res);
    beats_sent++;
    if (first) packets_sent++;
    // insert a random idle gap
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every expected beat has come back.
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Build one tracker message of the given kind, damage it, and stream it.
  task automatic send_message(input logic [1:0] kind, input int body_len, input flaw_t flaw);
    logic [7:0]  msg[$];
    logic [15:0] lens[$];
    logic [15:0] len;
    int          at;
    logic [1:0]  other;
    msg.push_back(CH_D);
    msg.push_back(CH_ONE);
    msg.push_back(CH_COLON);
    msg.push_back(kind_char(kind, 1'b0));
    repeat (body_len) msg.push_back(8'($urandom_range(255)));
    msg.push_back(CH_ONE);
    msg.push_back(CH_COLON);
    msg.push_back(CH_Y);
    msg.push_back(CH_ONE);
    msg.push_back(CH_COLON);
    msg.push_back(kind_char(kind, 1'b1));
    msg.push_back(CH_E);
    len = 16'(msg.size());
    case (flaw)
      FLAW_CORRUPT: begin
        at = $urandom_range(msg.size() - 1);
        msg[at] = 8'($urandom_range(255));
      end
      FLAW_LENGTH: begin
        if ($urandom_range(1)) len = 16'($urandom_range(65535));
        else len = 16'(msg.size() + $urandom_range(6) - 3);
      end
      FLAW_KIND_MISMATCH: begin
        other = (kind == K_ERROR) ? K_QUERY : kind + 2'd1;
        msg[msg.size() - 2] = kind_char(other, 1'b1);
      end
      FLAW_TRUNCATE: repeat ($urandom_range(1, 6)) void'(msg.pop_back());
      FLAW_EXTRA:    repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(255)));
      default: ;
    endcase
    foreach (msg[i]) lens.push_back(len);
    if (flaw == FLAW_LENGTH_SHIFT) begin
      // change the length from some byte on, often to one already passed
      at = $urandom_range(1, msg.size() - 1);
      for (int i = at; i < msg.size(); i++)
        lens[i] = $urandom_range(1) ? 16'($urandom_range(at)) : 16'($urandom_range(65535));
    end
    foreach (msg[i]) send_beat(msg[i], lens[i], i == 0);
  endtask

  // A few random bytes with random lengths and random packet start marks.
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_beat(8'($urandom_range(255)), 16'($urandom_range(65535)), $urandom_range(3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    logic [7:0] err_msg[$];
    err_msg = '{CH_D, CH_ONE, CH_COLON, CH_E, 8'h00, 8'hff,
                CH_ONE, CH_COLON, CH_Y, CH_ONE, CH_COLON, CH_E, CH_E};
    // no packet start after reset: shortest error message parsed from offset zero
    foreach (err_msg[i]) send_beat(err_msg[i], 16'd13, 1'b0);
    // short payload, then a byte that repeats the held verdict
    send_beat(CH_D, 16'd0, 1'b1);
    send_beat(8'hff, 16'hffff, 1'b0);
    // broken banner
    send_beat(8'h00, 16'd13, 1'b1);
    // good banner, bad kind byte, largest length
    send_beat(CH_D, 16'hffff, 1'b1);
    send_beat(CH_ONE, 16'hffff, 1'b0);
    send_beat(CH_COLON, 16'hffff, 1'b0);
    send_beat(8'h78, 16'hffff, 1'b0);
  endtask

  task automatic test_random_traffic(input int beats);
    int    stop_at;
    int    pick;
    int    body;
    flaw_t flaw;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_noise();
      end else begin
        body = ($urandom_range(9) == 0) ? $urandom_range(2, 120) : $urandom_range(2, 12);
        flaw = (pick < 55) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
        send_message(2'($urandom_range(1, 3)), body, flaw);
      end
    end
  endtask

  // Hold the receiver off for a long stretch while bytes keep coming.
  task automatic test_receiver_hold();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    send_message(K_RESPONSE, 2, FLAW_NONE);
    send_message(K_QUERY, 4, FLAW_NONE);
    send_idle_pct = saved_idle;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
             $realtime, beats_checked, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result beat with nothing expected, verdict", m_axis_tdata[1:0], 0);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[1:0] != want.verdict)
          report_mismatch("verdict", m_axis_tdata[1:0], want.verdict);
        if (m_axis_tdata[3:2] != want.message_kind)
          report_mismatch("message_kind", m_axis_tdata[3:2], want.message_kind);
        if (want.verdict == V_MATCH) matched_seen++;
        if (want.verdict == V_INVALID) invalid_seen++;
      end
      beats_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, verdict_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    send_idle_pct = 9;
    recv_idle_pct = 63;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(200);
    wait_for_results();
    test_receiver_hold();
    wait_for_results();

    send_idle_pct = 63;
    recv_idle_pct = 9;
    test_random_traffic(220);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(220);
    wait_for_results();
    repeat (5) @(posedge clk);

    $display("covered %0d bytes in %0d started packets, %0d results checked",
             beats_sent, packets_sent, beats_checked);
    $display("results: %0d matched, %0d invalid; %0d receiver hold-off(s) of %0d cycles",
             matched_seen, invalid_seen, holds_done, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/utmr_pkg.sv
src/utmr_parser.sv
src/utmr_out_reg.sv
src/udp_tracker_message_recognizer_core.sv
tb/udp_tracker_message_recognizer_core_test.sv
